@@ hw/rtl/gaussian_rbf_kernel_entry_top_macros.svh @@
// assertion macros for the kernel entry block
`ifndef GAUSSIAN_RBF_KERNEL_ENTRY_TOP_MACROS_SVH
`define GAUSSIAN_RBF_KERNEL_ENTRY_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define GRK_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define GRK_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/grk_pkg.sv @@
// shared types and constants for the kernel entry block
package grk_pkg;
    localparam int MaxRows = 4096;
    localparam int RowW = 13;
    localparam int SumW = 48;
    localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
    localparam int QDepth = 2;

    // register indexes
    localparam logic [1:0] REG_GAMMA = 2'd0;
    localparam logic [1:0] REG_DIAG_START = 2'd1;
    localparam logic [1:0] REG_DIAG_FINAL = 2'd2;
    localparam logic [1:0] REG_SINGLE_ROW = 2'd3;

    // finished sum handed from front to back
    typedef struct packed {
        logic [SumW-1:0] sum;
        logic            sat;
        logic [11:0]     row;
        logic [11:0]     col;
        logic            diag;
    } entry_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE, ST_SCALE, ST_SERIES, ST_SQUARE, ST_ROUND, ST_OUT
    } be_state_t;
endpackage

@@ hw/rtl/grk_front.sv @@
// front end: accumulates squared differences and classifies the diagonal
module grk_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [15:0]       x_value,
    input  logic [15:0]       y_value,
    input  logic [11:0]       row_index,
    input  logic [11:0]       col_index,
    input  logic              last_feature,
    input  logic [12:0]       diag_start,
    input  logic [12:0]       diag_final,
    input  logic              single_row,
    output logic              q_valid,
    input  logic              q_ready,
    output grk_pkg::entry_t   q_entry
);
    logic [grk_pkg::SumW-1:0] sum_reg, sum_next;
    logic sat_reg, sat_next;
    logic [16:0] diff;
    logic [16:0] mag;
    logic [33:0] sq;
    logic [grk_pkg::SumW:0] add;
    logic [12:0] lo, hi;
    logic [12:0] row_w;
    logic [12:0] rel;
    logic on_diag;
    logic acc;

    // a last feature needs room in the queue
    assign in_ready = q_ready;
    assign acc = in_valid && in_ready;

    // squared difference and saturating add
    assign diff = {x_value[15], x_value} - {y_value[15], y_value};
    assign mag = diff[16] ? (~diff + 17'd1) : diff;
    assign sq = mag * mag;
    assign add = {1'b0, sum_reg} + {15'd0, sq};
    always_comb begin
        sum_next = sum_reg;
        sat_next = sat_reg;
        if (acc) begin
            if (add[grk_pkg::SumW]) begin
                sum_next = grk_pkg::SumMax;
                sat_next = 1'b1;
            end else begin
                sum_next = add[grk_pkg::SumW-1:0];
            end
            if (last_feature) begin
                sum_next = '0;
                sat_next = 1'b0;
            end
        end
    end

    // forced diagonal test
    assign lo = (diag_start > 13'(grk_pkg::MaxRows)) ? 13'(grk_pkg::MaxRows) : diag_start;
    assign hi = (diag_final > 13'(grk_pkg::MaxRows)) ? 13'(grk_pkg::MaxRows) : diag_final;
    assign row_w = {1'b0, row_index};
    assign rel = row_w - lo;
    always_comb begin
        on_diag = 1'b0;
        if (row_w >= lo && row_w < hi) begin
            if (single_row) on_diag = (col_index == 12'd0);
            else on_diag = ({1'b0, col_index} == rel);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            sat_reg <= 1'b0;
        end else begin
            sum_reg <= sum_next;
            sat_reg <= sat_next;
        end
    end

    // entry handed to the queue
    assign q_valid = acc && last_feature;
    always_comb begin
        q_entry.sum = add[grk_pkg::SumW] ? grk_pkg::SumMax : add[grk_pkg::SumW-1:0];
        q_entry.sat = add[grk_pkg::SumW] | sat_reg;
        q_entry.row = row_index;
        q_entry.col = col_index;
        q_entry.diag = on_diag;
    end
endmodule

@@ hw/rtl/grk_queue.sv @@
// short fifo between front and back ends
module grk_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  grk_pkg::entry_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output grk_pkg::entry_t rd_data
);
    grk_pkg::entry_t mem_reg [grk_pkg::QDepth];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != 2'(grk_pkg::QDepth);
    assign rd_valid = cnt_reg != 2'd0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end
endmodule

@@ hw/rtl/grk_back.sv @@
// back end: exp(-gamma*sum) by series and repeated squaring; diagonal entries give 0x8000
module grk_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [23:0]     gamma,
    input  logic            q_valid,
    output logic            q_ready,
    input  grk_pkg::entry_t q_entry,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [15:0]     kernel_value,
    output logic [11:0]     out_row,
    output logic [11:0]     out_col,
    output logic            sum_saturated
);
    grk_pkg::be_state_t state_reg, state_next;
    grk_pkg::entry_t ent_reg;
    logic [47:0] p_hi_reg, p_lo_reg;
    logic [2:0] phase_reg;
    logic [2:0] k_reg;
    logic [63:0] t_reg;
    logic [33:0] e_reg;
    logic [32:0] term_reg;
    logic [31:0] tq_reg;
    logic [30:0] e30_reg;
    logic [15:0] kv_reg;
    logic [65:0] tprod;
    logic [31:0] tq;
    logic [32:0] rmul;
    logic [64:0] rprod;
    logic [32:0] tdiv;
    logic [30:0] sq_in;
    logic [61:0] sq;
    logic [30:0] sqr;
    logic [31:0] e30c;
    logic [33:0] e_fin;

    // series term, first half: floor(term*t>>32), t below 2^32 here
    assign tprod = term_reg * t_reg[31:0];
    assign tq = tprod[63:32];

    // series term, second half: divide by k through shifts or reciprocal multiplication
    always_comb begin
        case (k_reg)
            3'd3: rmul = 33'h0_AAAA_AAAB;
            3'd5: rmul = 33'h0_CCCC_CCCD;
            3'd6: rmul = 33'h0_AAAA_AAAB;
            3'd7: rmul = 33'h1_2492_4925;
            default: rmul = '0;
        endcase
    end
    assign rprod = {33'd0, tq_reg} * {32'd0, rmul};
    always_comb begin
        case (k_reg)
            3'd1: tdiv = {1'b0, tq_reg};
            3'd2: tdiv = {2'b0, tq_reg[31:1]};
            3'd3: tdiv = {1'b0, rprod[64:33]};
            3'd4: tdiv = {3'b0, tq_reg[31:2]};
            3'd5: tdiv = {2'b0, rprod[64:34]};
            3'd6: tdiv = {2'b0, rprod[64:34]};
            3'd7: tdiv = {3'b0, rprod[64:35]};
            default: tdiv = {1'b0, tq_reg};
        endcase
    end

    // squaring: the first pass takes the rounded series value
    assign e_fin = e_reg + 34'd2;
    assign e30c = {e_fin[33:2] > 32'h4000_0000} ? 32'h4000_0000 : e_fin[33:2];
    assign sq_in = (phase_reg == 3'd0 && t_reg < 64'(12 << 24)) ? 31'(e30c) : e30_reg;
    assign sq = sq_in * sq_in;
    assign sqr = 31'((sq + 62'(32'h2000_0000)) >> 30);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            grk_pkg::ST_IDLE: if (q_valid) state_next = grk_pkg::ST_SCALE;
            grk_pkg::ST_SCALE: if (phase_reg == 3'd1) state_next = grk_pkg::ST_SERIES;
            grk_pkg::ST_SERIES: if ((k_reg == 3'd7 && phase_reg == 3'd1)
                                    || t_reg >= 64'(12 << 24))
                state_next = grk_pkg::ST_SQUARE;
            grk_pkg::ST_SQUARE: if (phase_reg == 3'd7) state_next = grk_pkg::ST_ROUND;
            grk_pkg::ST_ROUND: state_next = grk_pkg::ST_OUT;
            grk_pkg::ST_OUT: if (m_ready) state_next = grk_pkg::ST_IDLE;
            default: state_next = grk_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        q_ready = (state_reg == grk_pkg::ST_IDLE);
        m_valid = (state_reg == grk_pkg::ST_OUT);
    end
    assign kernel_value = kv_reg;
    assign out_row = ent_reg.row;
    assign out_col = ent_reg.col;
    assign sum_saturated = ent_reg.sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= grk_pkg::ST_IDLE;
        else state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            grk_pkg::ST_IDLE: begin
                ent_reg <= q_entry;
                phase_reg <= 3'd0;
            end
            grk_pkg::ST_SCALE: begin
                if (phase_reg == 3'd0) begin
                    p_hi_reg <= gamma * ent_reg.sum[47:24];
                    p_lo_reg <= gamma * ent_reg.sum[23:0];
                    phase_reg <= 3'd1;
                end else begin
                    t_reg <= {8'd0, p_hi_reg, 8'd0} + {32'd0, p_lo_reg[47:16]};
                    e_reg <= 34'h1_0000_0000;
                    term_reg <= 33'h1_0000_0000;
                    k_reg <= 3'd1;
                    phase_reg <= 3'd0;
                end
            end
            grk_pkg::ST_SERIES: begin
                if (t_reg >= 64'(12 << 24)) begin
                    e30_reg <= '0;
                    phase_reg <= 3'd0;
                end else if (phase_reg == 3'd0) begin
                    tq_reg <= tq;
                    phase_reg <= 3'd1;
                end else begin
                    term_reg <= tdiv;
                    if (k_reg[0]) e_reg <= e_reg - 34'(tdiv);
                    else e_reg <= e_reg + 34'(tdiv);
                    k_reg <= k_reg + 3'd1;
                    phase_reg <= 3'd0;
                end
            end
            grk_pkg::ST_SQUARE: begin
                e30_reg <= sqr;
                phase_reg <= phase_reg + 3'd1;
            end
            grk_pkg::ST_ROUND: begin
                if (ent_reg.diag) kv_reg <= 16'h8000;
                else kv_reg <= 16'((e30_reg + 31'h4000) >> 15);
            end
            default: ;
        endcase
    end
endmodule

@@ hw/rtl/gaussian_rbf_kernel_entry_top.sv @@
// top level of the gaussian rbf kernel entry block
// Feature pairs are taken one per cycle into a saturating 48-bit sum; each
// last feature queues a finished entry for the exp back end, which handles
// one entry at a time: accept, scale, series, repeated squaring, round and
// output, skipping the series when the value underflows. Features pass at
// one per cycle while the two-deep queue has room; with the queue full the
// input stalls.
`include "gaussian_rbf_kernel_entry_top_macros.svh"
module gaussian_rbf_kernel_entry_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // x_value[15:0], y_value[31:16], row_index[43:32], col_index[55:44]
    input  logic [55:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // kernel_value[15:0], out_row[27:16], out_col[39:28], sum_saturated[40]
    output logic [47:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    logic [23:0] gamma_reg;
    logic [12:0] dstart_reg, dfinal_reg;
    logic single_reg;
    logic fq_valid, fq_ready, bq_valid, bq_ready;
    grk_pkg::entry_t fq_entry, bq_entry;
    logic [15:0] kv;
    logic [11:0] orow, ocol;
    logic osat;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_reg <= 24'd65536;
            dstart_reg <= '0;
            dfinal_reg <= '0;
            single_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                grk_pkg::REG_GAMMA: gamma_reg <= cfg_data;
                grk_pkg::REG_DIAG_START: dstart_reg <= cfg_data[12:0];
                grk_pkg::REG_DIAG_FINAL: dfinal_reg <= cfg_data[12:0];
                grk_pkg::REG_SINGLE_ROW: single_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    grk_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .x_value(s_tdata[15:0]), .y_value(s_tdata[31:16]),
        .row_index(s_tdata[43:32]), .col_index(s_tdata[55:44]),
        .last_feature(s_tlast),
        .diag_start(dstart_reg), .diag_final(dfinal_reg), .single_row(single_reg),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_entry(fq_entry)
    );

    grk_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_entry),
        .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_entry)
    );

    grk_back u_back (
        .aclk, .aresetn, .gamma(gamma_reg),
        .q_valid(bq_valid), .q_ready(bq_ready), .q_entry(bq_entry),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .kernel_value(kv), .out_row(orow), .out_col(ocol), .sum_saturated(osat)
    );

    assign m_tdata = {7'd0, osat, ocol, orow, kv};

    `GRK_ASSERT_IMP(a_kv_range, aclk, aresetn, m_tvalid, m_tdata[15:0] <= 16'h8000)
    `GRK_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `GRK_ASSERT_IMP(a_no_qloss, aclk, aresetn, s_tvalid && s_tready && s_tlast, fq_ready)
endmodule
